FILE: design/pdsw_pkg.sv
// shared types and constants for the page display shadow writer
package pdsw_pkg;

  // geometry defaults
  localparam int COLUMNS_DEF = 128;
  localparam int PAGES_DEF   = 8;
  // width of page * columns + column before it is cut to the store address
  localparam int ADDR_FULL_W = 10;

  // input item operation codes
  localparam logic [1:0] CMD_SET_CURSOR  = 2'd0;
  localparam logic [1:0] CMD_WRITE_DATA  = 2'd1;
  localparam logic [1:0] CMD_DRAW_POINT  = 2'd2;
  localparam logic [1:0] CMD_RAW_COMMAND = 2'd3;

  // position of a link byte within the sequence an item causes
  localparam logic [1:0] IDX_PAGE   = 2'd0;
  localparam logic [1:0] IDX_COL_HI = 2'd1;
  localparam logic [1:0] IDX_COL_LO = 2'd2;
  localparam logic [1:0] IDX_BYTE   = 2'd3;

  // panel addressing command bases
  localparam logic [7:0] LINK_PAGE_BASE   = 8'hB0;
  localparam logic [7:0] LINK_COL_HI_BASE = 8'h10;
  localparam logic [7:0] LINK_NIBBLE_MASK = 8'h0F;

  typedef struct packed {
    logic       clear_en;
    logic       accept;
    logic       modify;
    logic       emit;
    logic [1:0] emit_idx;
  } ctl_t;

  typedef struct packed {
    logic       out_free;
    logic       clear_last;
    logic       on_screen;
    logic [1:0] item_cmd;
    logic       emit_last;
  } sts_t;

endpackage

FILE: design/pdsw_if.sv
// item and result channel interfaces
interface pdsw_item_if;
  logic       valid;
  logic       ready;
  logic [1:0] cmd;
  logic [2:0] page;
  logic [6:0] column;
  logic [7:0] data_byte;
  logic [7:0] point_x;
  logic [7:0] point_y;
  logic       point_on;

  modport source (output valid, cmd, page, column, data_byte, point_x, point_y, point_on,
                  input ready);
  modport sink (input valid, cmd, page, column, data_byte, point_x, point_y, point_on,
                output ready);
endinterface

interface pdsw_result_if;
  logic       valid;
  logic       ready;
  logic [7:0] link_byte;
  logic       is_data;
  logic       last;

  modport source (output valid, link_byte, is_data, last, input ready);
  modport sink (input valid, link_byte, is_data, last, output ready);
endinterface

FILE: design/pdsw_ctrl.sv
// controller state machine: clearing pass, item accept, read-modify-write, byte emission
module pdsw_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  output logic             item_ready,
  input  pdsw_pkg::sts_t   sts,
  output pdsw_pkg::ctl_t   ctl
);

  localparam logic [1:0] S_CLEAR = 2'd0;
  localparam logic [1:0] S_IDLE  = 2'd1;
  localparam logic [1:0] S_MOD   = 2'd2;
  localparam logic [1:0] S_EMIT  = 2'd3;

  logic [1:0] state, state_next;
  logic [1:0] emit_idx, emit_idx_next;
  logic       accept;

  assign item_ready = (state == S_IDLE);
  assign accept     = item_valid && item_ready;

  always_comb begin
    ctl.clear_en = (state == S_CLEAR);
    ctl.accept   = accept;
    ctl.modify   = (state == S_MOD);
    ctl.emit     = (state == S_EMIT) && sts.out_free;
    ctl.emit_idx = emit_idx;
  end

  always_comb begin
    state_next    = state;
    emit_idx_next = emit_idx;
    case (state)
      S_CLEAR: begin
        if (sts.clear_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (accept) begin
          case (sts.item_cmd)
            pdsw_pkg::CMD_SET_CURSOR: begin
              state_next    = S_EMIT;
              emit_idx_next = pdsw_pkg::IDX_PAGE;
            end
            pdsw_pkg::CMD_DRAW_POINT: begin
              // off-screen points cause nothing
              if (sts.on_screen) begin
                state_next    = S_MOD;
                emit_idx_next = pdsw_pkg::IDX_PAGE;
              end
            end
            default: begin
              state_next    = S_EMIT;
              emit_idx_next = pdsw_pkg::IDX_BYTE;
            end
          endcase
        end
      end
      S_MOD: begin
        state_next = S_EMIT;
      end
      S_EMIT: begin
        if (ctl.emit) begin
          if (sts.emit_last) state_next = S_IDLE;
          else emit_idx_next = emit_idx + 2'd1;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      emit_idx <= pdsw_pkg::IDX_PAGE;
    end else begin
      state    <= state_next;
      emit_idx <= emit_idx_next;
    end
  end

  a_mod_then_emit: assert property (@(posedge clk) disable iff (rst)
    (state == S_MOD) |=> (state == S_EMIT) && (emit_idx == pdsw_pkg::IDX_PAGE))
    else $error("read-modify-write not followed by the page command");

  a_last_returns_idle: assert property (@(posedge clk) disable iff (rst)
    (ctl.emit && sts.emit_last) |=> (state == S_IDLE))
    else $error("controller did not return to idle after the last byte");

  a_clear_holds: assert property (@(posedge clk) disable iff (rst)
    (state == S_CLEAR && !sts.clear_last) |=> (state == S_CLEAR))
    else $error("clearing pass left early");

  a_emit_idx_range: assert property (@(posedge clk) disable iff (rst)
    (ctl.emit && !sts.emit_last) |-> (emit_idx != pdsw_pkg::IDX_BYTE))
    else $error("emission ran past the data byte");

endmodule

FILE: design/pdsw_dp.sv
// datapath: item registers, cursor, shadow store and output register
module pdsw_dp #(
  parameter int COLUMNS = pdsw_pkg::COLUMNS_DEF,
  parameter int PAGES   = pdsw_pkg::PAGES_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  pdsw_pkg::ctl_t   ctl,
  output pdsw_pkg::sts_t   sts,
  input  logic [1:0]       cmd,
  input  logic [2:0]       page,
  input  logic [6:0]       column,
  input  logic [7:0]       data_byte,
  input  logic [7:0]       point_x,
  input  logic [7:0]       point_y,
  input  logic             point_on,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [7:0]       link_byte,
  output logic             is_data,
  output logic             last
);

  localparam int DEPTH  = PAGES * COLUMNS;
  localparam int ADDR_W = $clog2(DEPTH);

  logic [7:0] store [DEPTH];

  logic [2:0]        cursor_page;
  logic [6:0]        cursor_column;
  logic [ADDR_W-1:0] clr_addr;

  // item registers
  logic [1:0]        cmd_q;
  logic [2:0]        page_q;
  logic [6:0]        col_q;
  logic [7:0]        byte_q;
  logic [ADDR_W-1:0] addr_q;
  logic [2:0]        bit_q;
  logic              on_q;

  logic [7:0]        rd_data;
  logic [ADDR_W-1:0] rd_addr;
  logic [ADDR_W-1:0] wr_addr;
  logic [7:0]        wr_data;
  logic              wr_en;
  logic [2:0]        pt_page;
  logic              cursor_in_store;
  logic [7:0]        mod_byte;
  logic [7:0]        emit_byte;

  function automatic logic [ADDR_W-1:0] addr_of(input logic [2:0] pg, input logic [6:0] col);
    logic [pdsw_pkg::ADDR_FULL_W-1:0] full;
    full = pdsw_pkg::ADDR_FULL_W'(pg) * pdsw_pkg::ADDR_FULL_W'(COLUMNS)
         + pdsw_pkg::ADDR_FULL_W'(col);
    return full[ADDR_W-1:0];
  endfunction

  function automatic logic [6:0] col_after(input logic [6:0] col);
    logic [7:0] inc;
    inc = {1'b0, col} + 8'd1;
    if (inc >= 8'(COLUMNS)) inc = 8'd0;
    return inc[6:0];
  endfunction

  assign pt_page         = point_y[5:3];
  assign cursor_in_store = ({1'b0, cursor_page} < 4'(PAGES))
                        && ({1'b0, cursor_column} < 8'(COLUMNS));
  assign rd_addr         = addr_of(pt_page, point_x[6:0]);
  assign mod_byte        = on_q ? (rd_data | (8'd1 << bit_q)) : (rd_data & ~(8'd1 << bit_q));

  always_comb begin
    sts.out_free   = !out_valid || out_ready;
    sts.clear_last = (clr_addr == ADDR_W'(DEPTH - 1));
    sts.on_screen  = (point_x < 8'(COLUMNS)) && (point_y < 8'(PAGES * 8));
    sts.item_cmd   = cmd;
    sts.emit_last  = (ctl.emit_idx == pdsw_pkg::IDX_BYTE)
                  || ((cmd_q == pdsw_pkg::CMD_SET_CURSOR)
                      && (ctl.emit_idx == pdsw_pkg::IDX_COL_LO));
  end

  // single write port: clearing pass, draw update, write data at the cursor
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = clr_addr;
    wr_data = 8'd0;
    if (ctl.clear_en) begin
      wr_en = 1'b1;
    end else if (ctl.modify) begin
      wr_en   = 1'b1;
      wr_addr = addr_q;
      wr_data = mod_byte;
    end else if (ctl.accept && cmd == pdsw_pkg::CMD_WRITE_DATA && cursor_in_store) begin
      wr_en   = 1'b1;
      wr_addr = addr_of(cursor_page, cursor_column);
      wr_data = data_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) store[wr_addr] <= wr_data;
    rd_data <= store[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (ctl.clear_en && !sts.clear_last) begin
      clr_addr <= clr_addr + ADDR_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cursor_page   <= 3'd0;
      cursor_column <= 7'd0;
    end else if (ctl.accept) begin
      case (cmd)
        pdsw_pkg::CMD_SET_CURSOR: begin
          cursor_page   <= page;
          cursor_column <= column;
        end
        pdsw_pkg::CMD_WRITE_DATA: begin
          cursor_column <= col_after(cursor_column);
        end
        pdsw_pkg::CMD_DRAW_POINT: begin
          if (sts.on_screen) begin
            cursor_page   <= pt_page;
            cursor_column <= col_after(point_x[6:0]);
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.accept) begin
      cmd_q  <= cmd;
      byte_q <= data_byte;
      addr_q <= rd_addr;
      bit_q  <= point_y[2:0];
      on_q   <= point_on;
      if (cmd == pdsw_pkg::CMD_DRAW_POINT) begin
        page_q <= pt_page;
        col_q  <= point_x[6:0];
      end else begin
        page_q <= page;
        col_q  <= column;
      end
    end else if (ctl.modify) begin
      byte_q <= mod_byte;
    end
  end

  always_comb begin
    case (ctl.emit_idx)
      pdsw_pkg::IDX_PAGE:   emit_byte = pdsw_pkg::LINK_PAGE_BASE | {5'd0, page_q};
      pdsw_pkg::IDX_COL_HI: emit_byte = pdsw_pkg::LINK_COL_HI_BASE | {5'd0, col_q[6:4]};
      pdsw_pkg::IDX_COL_LO: emit_byte = {1'b0, col_q} & pdsw_pkg::LINK_NIBBLE_MASK;
      default:              emit_byte = byte_q;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.emit) begin
      link_byte <= emit_byte;
      is_data   <= (ctl.emit_idx == pdsw_pkg::IDX_BYTE) && (cmd_q != pdsw_pkg::CMD_RAW_COMMAND);
      last      <= sts.emit_last;
    end
  end

endmodule

FILE: design/page_display_shadow_writer.sv
// page display shadow writer: shadow copy of a page-mode panel and its link byte stream
//
// item channel: one operation per item (set cursor, write data byte, draw point,
// raw command). result channel: link bytes tagged command or data, last marks the
// final byte an item causes.
// after reset the shadow store is zeroed one entry a cycle, all PAGES*COLUMNS entries
// (1024 by default); no item is taken until that pass ends, the cursor resets to 0.
// no new item is accepted until the last link byte of the current one has gone into
// the output register; an off-screen draw point causes no link byte at all.
// draw point reads the shadow store at accept, updates the byte in the next cycle,
// then emits four bytes; each byte goes out through a one-entry output register.
// after accept the controller goes to emission, draw point via the modify state first.
// a stalled receiver holds the output register; the block waits and loses nothing,
// and the next item can be accepted while the final byte of the last one waits.
module page_display_shadow_writer #(
  parameter int COLUMNS = pdsw_pkg::COLUMNS_DEF,
  parameter int PAGES   = pdsw_pkg::PAGES_DEF
) (
  input logic           clk,
  input logic           rst,
  pdsw_item_if.sink     item,
  pdsw_result_if.source result
);

  pdsw_pkg::ctl_t ctl;
  pdsw_pkg::sts_t sts;
  logic           item_ready;
  logic           out_valid;
  logic [7:0]     link_byte;
  logic           is_data;
  logic           last;

  assign item.ready       = item_ready;
  assign result.valid     = out_valid;
  assign result.link_byte = link_byte;
  assign result.is_data   = is_data;
  assign result.last      = last;

  pdsw_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item.valid),
    .item_ready (item_ready),
    .sts        (sts),
    .ctl        (ctl)
  );

  pdsw_dp #(
    .COLUMNS (COLUMNS),
    .PAGES   (PAGES)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .ctl       (ctl),
    .sts       (sts),
    .cmd       (item.cmd),
    .page      (item.page),
    .column    (item.column),
    .data_byte (item.data_byte),
    .point_x   (item.point_x),
    .point_y   (item.point_y),
    .point_on  (item.point_on),
    .out_valid (out_valid),
    .out_ready (result.ready),
    .link_byte (link_byte),
    .is_data   (is_data),
    .last      (last)
  );

endmodule
